[rtl/sbc_cdb_pkg.sv]
// shared types and constants for the sbc configuration decoder
`timescale 1ns / 1ps
package sbc_cdb_pkg;

    typedef struct packed {
        logic [7:0] rate_code;
        logic [3:0] mode_mask;
        logic [3:0] block_mask;
        logic [1:0] subband_mask;
        logic [7:0] max_pool;
    } t_sbc_cfg;

    typedef struct packed {
        logic [15:0] rate_hz;
        logic [1:0]  channel_count;
        logic [4:0]  block_count;
        logic [3:0]  subband_count;
        logic [10:0] frame_bytes;
        logic [22:0] bits_per_second;
    } t_sbc_info;

    localparam logic [15:0] RATE_16K = 16'd16000;
    localparam logic [15:0] RATE_32K = 16'd32000;
    localparam logic [15:0] RATE_44K = 16'd44100;
    localparam logic [15:0] RATE_48K = 16'd48000;

    localparam int unsigned RATE_MASK_16K = 7;
    localparam int unsigned RATE_MASK_32K = 6;
    localparam int unsigned RATE_MASK_44K = 5;
    localparam int unsigned RATE_MASK_48K = 4;

    localparam int unsigned MODE_MONO   = 3;
    localparam int unsigned MODE_STEREO = 1;
    localparam int unsigned MODE_JOINT  = 0;

    localparam int unsigned BLK_4  = 3;
    localparam int unsigned BLK_8  = 2;
    localparam int unsigned BLK_12 = 1;
    localparam int unsigned BLK_16 = 0;
    localparam int unsigned SB_4   = 1;
    localparam int unsigned SB_8   = 0;

    localparam logic [13:0] HEADER_BITS = 14'd32;
    localparam logic [22:0] BITRATE_MAX = 23'd8000000;
    // ceil(2^33 / 3), exact quotient by three for any 32-bit dividend
    localparam logic [31:0] RECIP_3     = 32'hAAAA_AAAB;

endpackage

[rtl/sbc_config_decode_bitrate_core.sv]
// sbc configuration decoder with frame length and bitrate estimate
//
// Decodes one sbc configuration request per cycle into sample rate, channel count,
// block count and subband count, then derives the frame length in bytes and the
// estimated bitrate from the maximum bitpool. Five register stages: field decode
// and blocks*bitpool product, frame length, frame*rate product, power-of-two
// shift plus reciprocal multiply for the divide by three, then quotient select
// and saturation into the output register. A new request is taken every
// cycle; the input stalls only when all five stages hold data and the output is
// stalled.
`timescale 1ns / 1ps
module sbc_config_decode_bitrate_core
    import sbc_cdb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_sbc_cfg  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_sbc_info o_out_data
);

    // stage valids and advance conditions
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5 = !r_s5_v || !i_out_stall;
    assign rdy4 = !r_s4_v || rdy5;
    assign rdy3 = !r_s3_v || rdy4;
    assign rdy2 = !r_s2_v || rdy3;
    assign rdy1 = !r_s1_v || rdy2;
    assign o_in_stall = !rdy1;

    // ---------------- stage 1: decode ----------------
    logic [15:0] n_s1_rate;
    logic [1:0]  n_s1_ch;
    logic [4:0]  n_s1_blk;
    logic [3:0]  n_s1_sb;
    logic [12:0] n_s1_bp;
    logic        n_s1_zero;
    logic [2:0]  n_s1_shift;
    logic        n_s1_div3;

    logic [15:0] r_s1_rate;
    logic [1:0]  r_s1_ch;
    logic [4:0]  r_s1_blk;
    logic [3:0]  r_s1_sb;
    logic [12:0] r_s1_bp;
    logic        r_s1_zero;
    logic        r_s1_joint;
    logic        r_s1_single;
    logic [2:0]  r_s1_shift;
    logic        r_s1_div3;

    always_comb begin
        if (i_in_data.rate_code <= 8'd3) begin
            case (i_in_data.rate_code[1:0])
                2'd0:    n_s1_rate = RATE_16K;
                2'd1:    n_s1_rate = RATE_32K;
                2'd2:    n_s1_rate = RATE_44K;
                default: n_s1_rate = RATE_48K;
            endcase
        end else if (i_in_data.rate_code[RATE_MASK_16K]) begin
            n_s1_rate = RATE_16K;
        end else if (i_in_data.rate_code[RATE_MASK_32K]) begin
            n_s1_rate = RATE_32K;
        end else if (i_in_data.rate_code[RATE_MASK_44K]) begin
            n_s1_rate = RATE_44K;
        end else if (i_in_data.rate_code[RATE_MASK_48K]) begin
            n_s1_rate = RATE_48K;
        end else begin
            n_s1_rate = 16'd0;
        end

        n_s1_ch = i_in_data.mode_mask[MODE_MONO] ? 2'd1 : 2'd2;

        // divisor subbands*blocks is 2^shift, times three for twelve blocks
        n_s1_div3 = 1'b0;
        if (i_in_data.block_mask[BLK_4]) begin
            n_s1_blk   = 5'd4;
            n_s1_shift = 3'd2;
        end else if (i_in_data.block_mask[BLK_8]) begin
            n_s1_blk   = 5'd8;
            n_s1_shift = 3'd3;
        end else if (i_in_data.block_mask[BLK_12]) begin
            n_s1_blk   = 5'd12;
            n_s1_shift = 3'd2;
            n_s1_div3  = 1'b1;
        end else if (i_in_data.block_mask[BLK_16]) begin
            n_s1_blk   = 5'd16;
            n_s1_shift = 3'd4;
        end else begin
            n_s1_blk   = 5'd0;
            n_s1_shift = 3'd0;
        end

        if (i_in_data.subband_mask[SB_4]) begin
            n_s1_sb    = 4'd4;
            n_s1_shift = n_s1_shift + 3'd2;
        end else if (i_in_data.subband_mask[SB_8]) begin
            n_s1_sb    = 4'd8;
            n_s1_shift = n_s1_shift + 3'd3;
        end else begin
            n_s1_sb    = 4'd0;
        end

        n_s1_bp   = 13'(n_s1_blk) * 13'(i_in_data.max_pool);
        n_s1_zero = (n_s1_rate == 16'd0) || (n_s1_blk == 5'd0) || (n_s1_sb == 4'd0)
                    || (i_in_data.max_pool == 8'd0);
    end

    // ---------------- stage 2: frame length ----------------
    logic [13:0] n_s2_audio;
    logic [13:0] n_s2_bits;
    logic [10:0] n_s2_frame;

    logic [10:0] r_s2_frame;
    logic [15:0] r_s2_rate;
    logic [1:0]  r_s2_ch;
    logic [4:0]  r_s2_blk;
    logic [3:0]  r_s2_sb;
    logic [2:0]  r_s2_shift;
    logic        r_s2_div3;

    always_comb begin
        if (r_s1_joint) begin
            n_s2_audio = 14'(r_s1_sb) + 14'(r_s1_bp);
        end else if (r_s1_single || r_s1_ch == 2'd1) begin
            n_s2_audio = 14'(r_s1_bp);
        end else begin
            n_s2_audio = {r_s1_bp, 1'b0};
        end
        n_s2_bits  = HEADER_BITS + ((14'(r_s1_sb) * 14'(r_s1_ch)) << 2) + n_s2_audio;
        n_s2_frame = r_s1_zero ? 11'd0 : 11'd4 + 11'((n_s2_bits + 14'd7) >> 3);
    end

    // ---------------- stage 3: frame * rate * 8 ----------------
    logic [29:0] n_s3_num;

    logic [29:0] r_s3_num;
    logic [10:0] r_s3_frame;
    logic [15:0] r_s3_rate;
    logic [1:0]  r_s3_ch;
    logic [4:0]  r_s3_blk;
    logic [3:0]  r_s3_sb;
    logic [2:0]  r_s3_shift;
    logic        r_s3_div3;

    assign n_s3_num = {27'(27'(r_s2_frame) * 27'(r_s2_rate)), 3'b000};

    // ---------------- stage 4: shift and reciprocal product ----------------
    logic [25:0] n_s4_y;
    logic [57:0] n_s4_prod;

    logic [25:0] r_s4_y;
    logic [57:0] r_s4_prod;
    logic [10:0] r_s4_frame;
    logic [15:0] r_s4_rate;
    logic [1:0]  r_s4_ch;
    logic [4:0]  r_s4_blk;
    logic [3:0]  r_s4_sb;
    logic        r_s4_div3;

    assign n_s4_y    = 26'(r_s3_num >> r_s3_shift);
    assign n_s4_prod = 58'(n_s4_y) * 58'(RECIP_3);

    // ---------------- stage 5: quotient and saturation ----------------
    logic [25:0] n_s5_q;
    logic [22:0] n_s5_bps;

    t_sbc_info r_s5_data;

    always_comb begin
        n_s5_q   = r_s4_div3 ? {1'b0, r_s4_prod[57:33]} : r_s4_y;
        n_s5_bps = (n_s5_q > 26'(BITRATE_MAX)) ? BITRATE_MAX : n_s5_q[22:0];
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
        end else begin
            if (rdy1) r_s1_v <= i_in_valid;
            if (rdy2) r_s2_v <= r_s1_v;
            if (rdy3) r_s3_v <= r_s2_v;
            if (rdy4) r_s4_v <= r_s3_v;
            if (rdy5) r_s5_v <= r_s4_v;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_rate   <= n_s1_rate;
            r_s1_ch     <= n_s1_ch;
            r_s1_blk    <= n_s1_blk;
            r_s1_sb     <= n_s1_sb;
            r_s1_bp     <= n_s1_bp;
            r_s1_zero   <= n_s1_zero;
            r_s1_joint  <= i_in_data.mode_mask[MODE_JOINT];
            r_s1_single <= i_in_data.mode_mask[MODE_MONO]
                           | i_in_data.mode_mask[MODE_STEREO];
            r_s1_shift  <= n_s1_shift;
            r_s1_div3   <= n_s1_div3;
        end
        if (rdy2) begin
            r_s2_frame <= n_s2_frame;
            r_s2_rate  <= r_s1_rate;
            r_s2_ch    <= r_s1_ch;
            r_s2_blk   <= r_s1_blk;
            r_s2_sb    <= r_s1_sb;
            r_s2_shift <= r_s1_shift;
            r_s2_div3  <= r_s1_div3;
        end
        if (rdy3) begin
            r_s3_num   <= n_s3_num;
            r_s3_frame <= r_s2_frame;
            r_s3_rate  <= r_s2_rate;
            r_s3_ch    <= r_s2_ch;
            r_s3_blk   <= r_s2_blk;
            r_s3_sb    <= r_s2_sb;
            r_s3_shift <= r_s2_shift;
            r_s3_div3  <= r_s2_div3;
        end
        if (rdy4) begin
            r_s4_y     <= n_s4_y;
            r_s4_prod  <= n_s4_prod;
            r_s4_frame <= r_s3_frame;
            r_s4_rate  <= r_s3_rate;
            r_s4_ch    <= r_s3_ch;
            r_s4_blk   <= r_s3_blk;
            r_s4_sb    <= r_s3_sb;
            r_s4_div3  <= r_s3_div3;
        end
        if (rdy5) begin
            r_s5_data.rate_hz         <= r_s4_rate;
            r_s5_data.channel_count   <= r_s4_ch;
            r_s5_data.block_count     <= r_s4_blk;
            r_s5_data.subband_count   <= r_s4_sb;
            r_s5_data.frame_bytes     <= r_s4_frame;
            r_s5_data.bits_per_second <= n_s5_bps;
        end
    end

    assign o_out_valid = r_s5_v;
    assign o_out_data  = r_s5_data;

    // a zero frame length always comes with a zero bitrate
    a_zero_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_bytes == 11'd0)
        |-> (o_out_data.bits_per_second == 23'd0))
        else $error("nonzero bitrate with zero frame length");

    a_bps_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.bits_per_second <= BITRATE_MAX))
        else $error("bitrate above saturation bound");

    a_frame_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.frame_bytes != 11'd0)
        |-> (o_out_data.rate_hz != 16'd0 && o_out_data.block_count != 5'd0
             && o_out_data.subband_count != 4'd0))
        else $error("frame length from a zero operand");

    // input backpressure only when the whole pipe is full behind a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_v && r_s2_v && r_s3_v && r_s4_v && r_s5_v && i_out_stall))
        else $error("input stalled with room in the pipeline");

endmodule
